// ===== hw/rtl/i2cbe_pkg.sv =====
// Package with the shared types, codes and phase tables of the I2C master bit engine.
`timescale 1ns / 1ps

package i2cbe_pkg;

   // Width of the phase counter; the longest command runs 25 phases.
   localparam int PHASE_W = 5;
   // Width of the bit-slot counter that steps through the three phases of one bit.
   localparam int SLOT_W = 2;
   localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(2);

   typedef enum logic [0:0] {
      KIND_COMMAND = 1'b0,
      KIND_TICK    = 1'b1
   } kind_type;

   typedef enum logic [2:0] {
      CMD_START     = 3'd0,
      CMD_STOP      = 3'd1,
      CMD_WRITE     = 3'd2,
      CMD_READ      = 3'd3,
      CMD_SEND_ACK  = 3'd4,
      CMD_RECV_ACK  = 3'd5
   } command_type;

   typedef enum logic [1:0] {
      STATUS_PHASE  = 2'd0,
      STATUS_IDLE   = 2'd1,
      STATUS_ACCEPT = 2'd2,
      STATUS_REJECT = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      OP_SDA_HI  = 3'd0,
      OP_SDA_LO  = 3'd1,
      OP_SCL_HI  = 3'd2,
      OP_SCL_LO  = 3'd3,
      OP_SDA_TX  = 3'd4,
      OP_SDA_ACK = 3'd5,
      OP_SAMPLE  = 3'd6
   } op_type;

   // One classified item as it travels from the front end to the back end.
   typedef struct packed {
      kind_type    kind;
      logic        cmd_ok;
      command_type command;
      logic [7:0]  data_byte;
      logic        ack_bit;
      logic        sda_level;
   } item_type;

   // Number of pin phases of each command.
   function automatic logic [PHASE_W-1:0] phase_count(input command_type cmd);
      logic [PHASE_W-1:0] cnt;
      unique case (cmd)
         CMD_START:    cnt = PHASE_W'(4);
         CMD_STOP:     cnt = PHASE_W'(3);
         CMD_WRITE:    cnt = PHASE_W'(24);
         CMD_READ:     cnt = PHASE_W'(25);
         CMD_SEND_ACK: cnt = PHASE_W'(3);
         default:      cnt = PHASE_W'(4);
      endcase
      return cnt;
   endfunction

   // Pin operation for a phase. Byte commands use the bit slot, the short
   // commands use the low bits of the phase counter.
   function automatic op_type phase_op(input command_type cmd,
                                       input logic [PHASE_W-1:0] phase,
                                       input logic [SLOT_W-1:0] slot);
      op_type op;
      op = OP_SCL_LO;
      unique case (cmd)
         CMD_START: begin
            case (phase[1:0])
               2'd0:    op = OP_SDA_HI;
               2'd1:    op = OP_SCL_HI;
               2'd2:    op = OP_SDA_LO;
               default: op = OP_SCL_LO;
            endcase
         end
         CMD_STOP: begin
            case (phase[1:0])
               2'd0:    op = OP_SDA_LO;
               2'd1:    op = OP_SCL_HI;
               default: op = OP_SDA_HI;
            endcase
         end
         CMD_WRITE: begin
            case (slot)
               2'd0:    op = OP_SDA_TX;
               2'd1:    op = OP_SCL_HI;
               default: op = OP_SCL_LO;
            endcase
         end
         CMD_READ: begin
            if (phase == '0) begin
               op = OP_SDA_HI;
            end else begin
               case (slot)
                  2'd0:    op = OP_SCL_HI;
                  2'd1:    op = OP_SAMPLE;
                  default: op = OP_SCL_LO;
               endcase
            end
         end
         CMD_SEND_ACK: begin
            case (phase[1:0])
               2'd0:    op = OP_SDA_ACK;
               2'd1:    op = OP_SCL_HI;
               default: op = OP_SCL_LO;
            endcase
         end
         default: begin
            case (phase[1:0])
               2'd0:    op = OP_SDA_HI;
               2'd1:    op = OP_SCL_HI;
               2'd2:    op = OP_SAMPLE;
               default: op = OP_SCL_LO;
            endcase
         end
      endcase
      return op;
   endfunction

endpackage

// ===== hw/rtl/i2cbe_front.sv =====
// Front end: accepts request items, classifies them and queues them for the back end.
`timescale 1ns / 1ps

module i2cbe_front
   import i2cbe_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic       req_kind,
   input  logic [2:0] req_command,
   input  logic [7:0] req_data_byte,
   input  logic       req_ack_bit,
   input  logic       req_sda_level,
   output logic       q_valid,
   output item_type   q_item,
   input  logic       q_pop
);

   localparam int DEPTH = 2;

   item_type   q_ff [DEPTH];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push;
   item_type   classified;

   // Classify the incoming item; unknown command codes are flagged here.
   always_comb begin
      classified.kind      = kind_type'(req_kind);
      classified.cmd_ok    = (req_command <= 3'(CMD_RECV_ACK));
      classified.command   = command_type'(req_command);
      classified.data_byte = req_data_byte;
      classified.ack_bit   = req_ack_bit;
      classified.sda_level = req_sda_level;
   end

   assign req_stall = (count_ff == 2'(DEPTH));
   assign push      = req_valid && !req_stall;
   assign q_valid   = (count_ff != '0);
   assign q_item    = q_ff[rd_ptr_ff];

   // Queue pointers and fill count.
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = q_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage holds payload only.
   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= classified;
      end
   end

endmodule

// ===== hw/rtl/i2cbe_back.sv =====
// Back end: runs the bit sequencer on queued items and holds the result register.
`timescale 1ns / 1ps

module i2cbe_back
   import i2cbe_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       q_valid,
   input  item_type   q_item,
   output logic       q_pop,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_scl_level,
   output logic       rsp_sda_drive,
   output logic       rsp_done_res,
   output logic [7:0] rsp_read_data,
   output logic       rsp_ack_received,
   output logic [1:0] rsp_status
);

   // Sequencer state.
   logic               busy_ff, busy_in;
   command_type        cmd_ff, cmd_in;
   logic [PHASE_W-1:0] phase_ff, phase_in;
   logic [SLOT_W-1:0]  slot_ff, slot_in;
   logic [7:0]         tx_ff, tx_in;
   logic [7:0]         rx_ff, rx_in;
   logic               ack_ff, ack_in;
   logic               scl_ff, scl_in;
   logic               sda_ff, sda_in;

   // Result register.
   logic               rsp_valid_ff, rsp_valid_in;
   logic               done_ff, done_in;
   logic [7:0]         rdata_ff, rdata_in;
   logic               ackr_ff, ackr_in;
   status_type         status_ff, status_in;

   logic               take;
   op_type             op;
   logic [PHASE_W-1:0] phase_next;

   // An item moves on whenever the result register is free or being emptied.
   assign take = q_valid && (!rsp_valid_ff || !rsp_stall);
   assign q_pop = take;

   assign op         = phase_op(cmd_ff, phase_ff, slot_ff);
   assign phase_next = phase_ff + PHASE_W'(1);

   // Next state and result for the item at the head of the queue.
   always_comb begin
      busy_in   = busy_ff;
      cmd_in    = cmd_ff;
      phase_in  = phase_ff;
      slot_in   = slot_ff;
      tx_in     = tx_ff;
      rx_in     = rx_ff;
      ack_in    = ack_ff;
      scl_in    = scl_ff;
      sda_in    = sda_ff;
      done_in   = 1'b0;
      rdata_in  = '0;
      ackr_in   = 1'b0;
      status_in = STATUS_IDLE;
      if (q_item.kind == KIND_COMMAND) begin
         if (busy_ff || !q_item.cmd_ok) begin
            status_in = STATUS_REJECT;
         end else begin
            busy_in   = 1'b1;
            cmd_in    = q_item.command;
            phase_in  = '0;
            slot_in   = '0;
            tx_in     = q_item.data_byte;
            ack_in    = q_item.ack_bit;
            rx_in     = '0;
            status_in = STATUS_ACCEPT;
         end
      end else if (busy_ff) begin
         unique case (op)
            OP_SDA_HI:  sda_in = 1'b1;
            OP_SDA_LO:  sda_in = 1'b0;
            OP_SCL_HI:  scl_in = 1'b1;
            OP_SCL_LO:  scl_in = 1'b0;
            OP_SDA_TX: begin
               sda_in = tx_ff[7];
               tx_in  = {tx_ff[6:0], 1'b0};
            end
            OP_SDA_ACK: sda_in = ack_ff;
            default:    rx_in  = {rx_ff[6:0], q_item.sda_level};
         endcase
         status_in = STATUS_PHASE;
         phase_in  = phase_next;
         // The read command holds its bit slot on its leading release phase.
         if (cmd_ff == CMD_READ && phase_ff == '0) begin
            slot_in = '0;
         end else begin
            slot_in = (slot_ff == SLOT_LAST) ? '0 : slot_ff + SLOT_W'(1);
         end
         if (phase_next >= phase_count(cmd_ff)) begin
            done_in  = 1'b1;
            busy_in  = 1'b0;
            phase_in = '0;
            if (cmd_ff == CMD_READ) begin
               rdata_in = rx_in;
            end else if (cmd_ff == CMD_RECV_ACK) begin
               ackr_in = rx_in[0];
            end
         end
      end
   end

   always_comb begin
      if (take) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Control state and pin registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         cmd_ff       <= CMD_START;
         phase_ff     <= '0;
         slot_ff      <= '0;
         tx_ff        <= '0;
         rx_ff        <= '0;
         ack_ff       <= 1'b0;
         scl_ff       <= 1'b1;
         sda_ff       <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (take) begin
            busy_ff  <= busy_in;
            cmd_ff   <= cmd_in;
            phase_ff <= phase_in;
            slot_ff  <= slot_in;
            tx_ff    <= tx_in;
            rx_ff    <= rx_in;
            ack_ff   <= ack_in;
            scl_ff   <= scl_in;
            sda_ff   <= sda_in;
         end
      end
   end

   // Result payload.
   always_ff @(posedge clock) begin
      if (take) begin
         done_ff   <= done_in;
         rdata_ff  <= rdata_in;
         ackr_ff   <= ackr_in;
         status_ff <= status_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_scl_level    = scl_ff;
   assign rsp_sda_drive    = sda_ff;
   assign rsp_done_res     = done_ff;
   assign rsp_read_data    = rdata_ff;
   assign rsp_ack_received = ackr_ff;
   assign rsp_status       = status_ff;

endmodule

// ===== hw/rtl/i2c_master_bit_engine.sv =====
// Top level of the I2C master bit engine: front end, item queue and back end.
//
//   Channel | Direction | Handshake         | Payload
//   req_    | in        | req_valid/stall   | kind, command, data_byte, ack_bit, sda_level
//   rsp_    | out       | rsp_valid/stall   | scl_level, sda_drive, done_res, read_data,
//           |           |                   | ack_received, status
//
// One item is accepted per cycle while nothing stalls and gives one result item, through the queue and result register.
// The rate is set by the back-end sequencer, which updates its state once for each item it takes.
// A two-entry queue between front and back keeps the input flowing while a result waits.
// Reset (synchronous) empties the queue, clears the sequencer and releases SCL and SDA.
// A stalled result holds the back end; the input stalls only once the queue is full.
`timescale 1ns / 1ps

module i2c_master_bit_engine
   import i2cbe_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic       req_kind,
   input  logic [2:0] req_command,
   input  logic [7:0] req_data_byte,
   input  logic       req_ack_bit,
   input  logic       req_sda_level,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_scl_level,
   output logic       rsp_sda_drive,
   output logic       rsp_done_res,
   output logic [7:0] rsp_read_data,
   output logic       rsp_ack_received,
   output logic [1:0] rsp_status
);

   logic     q_valid;
   logic     q_pop;
   item_type q_item;

   i2cbe_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_kind      (req_kind),
      .req_command   (req_command),
      .req_data_byte (req_data_byte),
      .req_ack_bit   (req_ack_bit),
      .req_sda_level (req_sda_level),
      .q_valid       (q_valid),
      .q_item        (q_item),
      .q_pop         (q_pop)
   );

   i2cbe_back u_back (
      .clock            (clock),
      .reset            (reset),
      .q_valid          (q_valid),
      .q_item           (q_item),
      .q_pop            (q_pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_scl_level    (rsp_scl_level),
      .rsp_sda_drive    (rsp_sda_drive),
      .rsp_done_res     (rsp_done_res),
      .rsp_read_data    (rsp_read_data),
      .rsp_ack_received (rsp_ack_received),
      .rsp_status       (rsp_status)
   );

endmodule

// ===== hw/rtl/i2cbe_checker.sv =====
// Port-level checks of the I2C master bit engine and their binding to the top level.
`timescale 1ns / 1ps

module i2cbe_checker
   import i2cbe_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic       rsp_scl_level,
   input logic       rsp_sda_drive,
   input logic       rsp_done_res,
   input logic [7:0] rsp_read_data,
   input logic       rsp_ack_received,
   input logic [1:0] rsp_status
);

   // No result item is shown in the cycle after reset.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // Done is reported only on a pin phase.
   a_done_phase: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_done_res |-> rsp_status == STATUS_PHASE)
      else $error("done on an item that is not a pin phase");

   // Read data and the received ack are zero unless a command completes.
   a_data_with_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_done_res |-> rsp_read_data == 8'h00 && !rsp_ack_received)
      else $error("read data or ack shown without done");

   // Idle ticks and rejected commands never complete a command.
   a_idle_no_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STATUS_IDLE || rsp_status == STATUS_REJECT)
      |-> !rsp_done_res)
      else $error("done on an idle tick or rejected command");

   // A stalled result item holds its payload.
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_read_data) && $stable(rsp_scl_level) && $stable(rsp_sda_drive))
      else $error("stalled result item changed");

endmodule

bind i2c_master_bit_engine i2cbe_checker u_checker (.*);
